### src/lcd_mode_timing_sequencer_assert.svh
// Assertion macros for the LCD mode timing sequencer.
`ifndef LCD_MODE_TIMING_SEQUENCER_ASSERT_SVH
`define LCD_MODE_TIMING_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define LMTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define LMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define LMTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/lcd_mts_pkg.sv
// Types and constants shared by the LCD mode timing sequencer files.
package lcd_mts_pkg;

	localparam int ACC_W   = 10;
	localparam int LINE_W  = 8;
	localparam int CYC_W   = 7;
	localparam int EN_W    = 4;
	localparam int CFG_D_W = 8;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_DRAW   = 2'd3
	} lcd_mode_t;

	typedef enum logic [0:0] {
		REG_STAT_EN  = 1'b0,
		REG_LINE_CMP = 1'b1
	} cfg_reg_t;

	localparam logic [ACC_W-1:0] OAM_CYCLES    = 10'd80;
	localparam logic [ACC_W-1:0] DRAW_CYCLES   = 10'd172;
	localparam logic [ACC_W-1:0] LINE_CYCLES   = 10'd456;
	localparam logic [ACC_W-1:0] HBLANK_CYCLES = LINE_CYCLES - OAM_CYCLES - DRAW_CYCLES;

	localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
	localparam logic [LINE_W-1:0] LINE_WRAP         = 8'd153;

	localparam int EN_HBLANK = 0;
	localparam int EN_VBLANK = 1;
	localparam int EN_OAM    = 2;
	localparam int EN_LYC    = 3;

endpackage

### src/lcd_mts_ifs.sv
// Channel interfaces for the LCD mode timing sequencer.
interface lcd_mts_cycles_if;
	logic                                valid;
	logic                                ready;
	logic [lcd_mts_pkg::CYC_W-1:0]       elapsed_cycles;
	modport source (output valid, output elapsed_cycles, input ready);
	modport sink (input valid, input elapsed_cycles, output ready);
endinterface

interface lcd_mts_result_if;
	logic                                valid;
	logic                                ready;
	logic [lcd_mts_pkg::LINE_W-1:0]      current_line;
	logic [1:0]                          lcd_mode;
	logic                                coincidence;
	logic                                vblank_irq;
	logic                                stat_irq;
	logic                                render_request;
	modport source (output valid, output current_line, output lcd_mode, output coincidence,
		output vblank_irq, output stat_irq, output render_request, input ready);
	modport sink (input valid, input current_line, input lcd_mode, input coincidence,
		input vblank_irq, input stat_irq, input render_request, output ready);
endinterface

interface lcd_mts_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [0:0]                          index;
	logic [lcd_mts_pkg::CFG_D_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### src/lcd_mode_timing_sequencer.sv
// Top level of the LCD mode timing sequencer: mode, line and interrupt timing.
// An accepted beat is registered in the input stage, then in the result stage, before its result appears.
// Throughput: one beat per cycle while the result is not stalled; the mode update is one add, compare and subtract.
// A stalled result holds both stages; the input is taken whenever the result stage can move.
// Reset is asynchronous: OAM scan, line 0, empty accumulator, both stage valid flags and config registers clear.
`include "lcd_mode_timing_sequencer_assert.svh"

module lcd_mode_timing_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	lcd_mts_cycles_if.sink    cycles,
	lcd_mts_result_if.source  result,
	lcd_mts_cfg_if.sink       cfg
);

	logic [lcd_mts_pkg::EN_W-1:0]   stat_en_q;
	logic [lcd_mts_pkg::LINE_W-1:0] line_cmp_q;

	lcd_mts_pkg::lcd_mode_t         mode_q, mode_d;
	logic [lcd_mts_pkg::LINE_W-1:0] line_q, line_d, line_inc;
	logic [lcd_mts_pkg::ACC_W-1:0]  acc_q, acc_d, acc;
	logic                           coin_q, coin_d;
	logic                           line_step, fire;

	logic                           s1_valid_q;
	logic [lcd_mts_pkg::CYC_W-1:0]  elapsed_s1;

	logic                           out_valid_q;
	logic [lcd_mts_pkg::LINE_W-1:0] line_s2;
	lcd_mts_pkg::lcd_mode_t         mode_s2;
	logic                           coin_s2, vblank_s2, stat_s2, render_s2;
	logic                           vblank_irq, stat_irq, render;
	logic                           advance;

	assign advance      = !out_valid_q || result.ready;
	assign cycles.ready = advance;
	assign cfg.ready    = 1'b1;

	assign acc      = acc_q + {{(lcd_mts_pkg::ACC_W - lcd_mts_pkg::CYC_W){1'b0}}, elapsed_s1};
	assign line_inc = line_q + 8'd1;

	// Next state of the mode sequencer.
	always_comb begin
		mode_d    = mode_q;
		line_d    = line_q;
		acc_d     = acc;
		line_step = 1'b0;
		fire      = 1'b0;
		case (mode_q)
			lcd_mts_pkg::MODE_OAM: begin
				if (acc >= lcd_mts_pkg::OAM_CYCLES) begin
					fire   = 1'b1;
					acc_d  = acc - lcd_mts_pkg::OAM_CYCLES;
					mode_d = lcd_mts_pkg::MODE_DRAW;
				end
			end
			lcd_mts_pkg::MODE_DRAW: begin
				if (acc >= lcd_mts_pkg::DRAW_CYCLES) begin
					fire   = 1'b1;
					acc_d  = acc - lcd_mts_pkg::DRAW_CYCLES;
					mode_d = lcd_mts_pkg::MODE_HBLANK;
				end
			end
			lcd_mts_pkg::MODE_HBLANK: begin
				if (acc >= lcd_mts_pkg::HBLANK_CYCLES) begin
					fire      = 1'b1;
					acc_d     = acc - lcd_mts_pkg::HBLANK_CYCLES;
					line_d    = line_inc;
					line_step = 1'b1;
					mode_d    = (line_inc == lcd_mts_pkg::FIRST_VBLANK_LINE) ?
						lcd_mts_pkg::MODE_VBLANK : lcd_mts_pkg::MODE_OAM;
				end
			end
			lcd_mts_pkg::MODE_VBLANK: begin
				if (acc >= lcd_mts_pkg::LINE_CYCLES) begin
					fire      = 1'b1;
					acc_d     = acc - lcd_mts_pkg::LINE_CYCLES;
					line_step = 1'b1;
					if (line_inc >= lcd_mts_pkg::LINE_WRAP) begin
						line_d = '0;
						mode_d = lcd_mts_pkg::MODE_OAM;
					end else begin
						line_d = line_inc;
					end
				end
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
		coin_d = line_step ? (line_d == line_cmp_q) : coin_q;
	end

	// Interrupt and render pulses.
	always_comb begin
		render     = fire && (mode_q == lcd_mts_pkg::MODE_DRAW) &&
			(line_q < lcd_mts_pkg::FIRST_VBLANK_LINE);
		vblank_irq = fire && (mode_q == lcd_mts_pkg::MODE_HBLANK) &&
			(line_inc == lcd_mts_pkg::FIRST_VBLANK_LINE);
		stat_irq   = (fire && (mode_q == lcd_mts_pkg::MODE_DRAW) &&
				stat_en_q[lcd_mts_pkg::EN_HBLANK]) ||
			(line_step && (line_d == line_cmp_q) && stat_en_q[lcd_mts_pkg::EN_LYC]) ||
			(vblank_irq && stat_en_q[lcd_mts_pkg::EN_VBLANK]) ||
			(fire && (mode_q == lcd_mts_pkg::MODE_HBLANK) && !vblank_irq &&
				stat_en_q[lcd_mts_pkg::EN_OAM]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_en_q  <= '0;
			line_cmp_q <= '0;
		end else if (cfg.valid) begin
			case (lcd_mts_pkg::cfg_reg_t'(cfg.index))
				lcd_mts_pkg::REG_STAT_EN:  stat_en_q  <= cfg.data[lcd_mts_pkg::EN_W-1:0];
				lcd_mts_pkg::REG_LINE_CMP: line_cmp_q <= cfg.data;
				default: begin
					stat_en_q <= stat_en_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= lcd_mts_pkg::MODE_OAM;
			line_q      <= '0;
			acc_q       <= '0;
			coin_q      <= 1'b0;
		end else if (advance) begin
			s1_valid_q  <= cycles.valid;
			out_valid_q <= s1_valid_q;
			if (s1_valid_q) begin
				mode_q <= mode_d;
				line_q <= line_d;
				acc_q  <= acc_d;
				coin_q <= coin_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cycles.valid) begin
			elapsed_s1 <= cycles.elapsed_cycles;
		end
		if (advance && s1_valid_q) begin
			line_s2   <= line_d;
			mode_s2   <= mode_d;
			coin_s2   <= coin_d;
			vblank_s2 <= vblank_irq;
			stat_s2   <= stat_irq;
			render_s2 <= render;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.current_line   = line_s2;
	assign result.lcd_mode       = mode_s2;
	assign result.coincidence    = coin_s2;
	assign result.vblank_irq     = vblank_s2;
	assign result.stat_irq       = stat_s2;
	assign result.render_request = render_s2;

	`LMTS_ASSERT_IMP(a_line_range, clk, arst_n, 1'b1, line_q < lcd_mts_pkg::LINE_WRAP)
	`LMTS_ASSERT_IMP(a_render_hblank, clk, arst_n, out_valid_q && render_s2, mode_s2 == lcd_mts_pkg::MODE_HBLANK)
	`LMTS_ASSERT_IMP(a_vblank_line, clk, arst_n, out_valid_q && vblank_s2, line_s2 == lcd_mts_pkg::FIRST_VBLANK_LINE)
	`LMTS_ASSERT_IMP(a_vblank_mode, clk, arst_n, out_valid_q && vblank_s2, mode_s2 == lcd_mts_pkg::MODE_VBLANK)
	`LMTS_ASSERT_NEXT(a_stage_hold, clk, arst_n, s1_valid_q && !advance, s1_valid_q && $stable(elapsed_s1))

endmodule
